/* sv/tfsc_pkg.sv */
// Package: types, codes and sizes of the TCP flag statistics counters.
package tfsc_pkg;

  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH       = 32;
  localparam int unsigned SIZE_WIDTH      = 16;
  localparam int unsigned NUM_DIRS        = 2;
  localparam int unsigned NUM_KINDS       = 5;

  localparam logic [1:0] ACT_PACKET    = 2'd0;
  localparam logic [1:0] ACT_CLEAR_INT = 2'd1;
  localparam logic [1:0] ACT_CLEAR_ALL = 2'd2;
  localparam logic [1:0] ACT_READ      = 2'd3;

  localparam int unsigned KIND_SYN    = 0;
  localparam int unsigned KIND_SYNACK = 1;
  localparam int unsigned KIND_FIN    = 2;
  localparam int unsigned KIND_RST    = 3;
  localparam int unsigned KIND_ZWIN   = 4;

  localparam int unsigned FLAG_FIN = 0;
  localparam int unsigned FLAG_SYN = 1;
  localparam int unsigned FLAG_RST = 2;
  localparam int unsigned FLAG_ACK = 4;

  typedef struct packed {
    logic [1:0]            action;
    logic [1:0]            direction;
    logic [7:0]            tcp_flags;
    logic [15:0]           window_size;
    logic [SIZE_WIDTH-1:0] packet_size;
  } req_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0]  syn_interval;
    logic [OUT_WIDTH-1:0]  synack_interval;
    logic [OUT_WIDTH-1:0]  fin_interval;
    logic [OUT_WIDTH-1:0]  rst_interval;
    logic [OUT_WIDTH-1:0]  zero_window_interval;
    logic [OUT_WIDTH-1:0]  syn_total;
    logic [OUT_WIDTH-1:0]  synack_total;
    logic [OUT_WIDTH-1:0]  fin_total;
    logic [OUT_WIDTH-1:0]  rst_total;
    logic [OUT_WIDTH-1:0]  zero_window_total;
    logic [SIZE_WIDTH-1:0] largest_packet;
  } rsp_t;

endpackage

/* sv/tfsc_ram.sv */
// Generic RAM: one write port, two registered read ports.
module tfsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_a_i,
  input  logic [AddrWidth-1:0] raddr_b_i,
  output logic [Width-1:0]     rdata_a_o,
  output logic [Width-1:0]     rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* sv/tcp_flag_statistics_counters_top.sv */
// Top level: per-direction TCP flag counters kept in a row RAM with read-modify-write.
//
//   channel | signals                       | payload
//   request | in_valid_i / in_ready_o       | in_i  (tfsc_pkg::req_t)
//   result  | out_valid_o / out_ready_i     | out_o (tfsc_pkg::rsp_t)
//
// One request per cycle while in_ready_o is high; the RAM is read at the accepting edge,
// then one row-update stage feeds the output register that raises out_valid_o.
// One RAM row per direction; both rows are read each request for merged reports,
// and a back-to-back write to a row being read is served by forwarding.
// Reset clears valid and forwarding flags, not RAM rows; an invalid row reads as zero.
// When the output register is held, an item in the update stage stalls and in_ready_o drops.
module tcp_flag_statistics_counters_top #(
  parameter int unsigned COUNT_WIDTH = tfsc_pkg::DEF_COUNT_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tfsc_pkg::req_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tfsc_pkg::rsp_t  out_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned NK     = tfsc_pkg::NUM_KINDS;
  localparam int unsigned SW     = tfsc_pkg::SIZE_WIDTH;
  localparam int unsigned OW     = tfsc_pkg::OUT_WIDTH;
  localparam int unsigned RowW   = 2 * NK * CW + SW;
  localparam int unsigned TotOff = NK * CW;
  localparam int unsigned LgOff  = 2 * NK * CW;

  logic                          s1_valid_q;
  tfsc_pkg::req_t                s1_q;
  logic                          s1_fire;
  logic                          in_fire;
  logic                          out_valid_q;
  tfsc_pkg::rsp_t                out_q;
  logic [tfsc_pkg::NUM_DIRS-1:0] iv_q;
  logic [tfsc_pkg::NUM_DIRS-1:0] tv_q;
  logic                          fwd_a_q;
  logic                          fwd_b_q;
  logic [RowW-1:0]               fwd_data_q;

  logic            we;
  logic            row_a;
  logic            row_b;
  logic            merged;
  logic [RowW-1:0] rd_a;
  logic [RowW-1:0] rd_b;
  logic [RowW-1:0] src_a;
  logic [RowW-1:0] src_b;
  logic [RowW-1:0] wdata;

  logic [CW-1:0] a_iv [NK];
  logic [CW-1:0] a_tv [NK];
  logic [CW-1:0] b_iv [NK];
  logic [CW-1:0] b_tv [NK];
  logic [SW-1:0] a_lg;
  logic [SW-1:0] b_lg;
  logic [NK-1:0] hit;
  logic [CW:0]   sum_iv [NK];
  logic [CW:0]   sum_tv [NK];
  logic [CW-1:0] rep_iv [NK];
  logic [CW-1:0] rep_tv [NK];
  logic [OW-1:0] cl_iv  [NK];
  logic [OW-1:0] cl_tv  [NK];
  logic [SW-1:0] rep_lg;
  tfsc_pkg::rsp_t rsp;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign row_a  = s1_q.direction[0];
  assign row_b  = ~s1_q.direction[0];
  assign merged = s1_q.direction[1];
  assign we     = s1_fire && (s1_q.action == tfsc_pkg::ACT_PACKET) && !merged;

  tfsc_ram #(
    .Width(RowW),
    .Depth(tfsc_pkg::NUM_DIRS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (row_a),
    .wdata_i  (wdata),
    .re_i     (in_fire),
    .raddr_a_i(in_i.direction[0]),
    .raddr_b_i(~in_i.direction[0]),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign src_a = fwd_a_q ? fwd_data_q : rd_a;
  assign src_b = fwd_b_q ? fwd_data_q : rd_b;

  always_comb begin
    hit = '0;
    hit[tfsc_pkg::KIND_RST]    = s1_q.tcp_flags[tfsc_pkg::FLAG_RST];
    hit[tfsc_pkg::KIND_ZWIN]   = (s1_q.window_size == '0) &&
                                 !s1_q.tcp_flags[tfsc_pkg::FLAG_RST];
    hit[tfsc_pkg::KIND_SYNACK] = s1_q.tcp_flags[tfsc_pkg::FLAG_SYN] &&
                                 s1_q.tcp_flags[tfsc_pkg::FLAG_ACK];
    hit[tfsc_pkg::KIND_SYN]    = s1_q.tcp_flags[tfsc_pkg::FLAG_SYN] &&
                                 !s1_q.tcp_flags[tfsc_pkg::FLAG_ACK];
    hit[tfsc_pkg::KIND_FIN]    = s1_q.tcp_flags[tfsc_pkg::FLAG_FIN] &&
                                 !s1_q.tcp_flags[tfsc_pkg::FLAG_SYN];
  end

  // effective rows after this request's action
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      a_iv[k] = iv_q[row_a] ? src_a[k*CW +: CW] : '0;
      a_tv[k] = tv_q[row_a] ? src_a[TotOff + k*CW +: CW] : '0;
      b_iv[k] = iv_q[row_b] ? src_b[k*CW +: CW] : '0;
      b_tv[k] = tv_q[row_b] ? src_b[TotOff + k*CW +: CW] : '0;
    end
    a_lg = tv_q[row_a] ? src_a[LgOff +: SW] : '0;
    b_lg = tv_q[row_b] ? src_b[LgOff +: SW] : '0;
    case (s1_q.action)
      tfsc_pkg::ACT_PACKET: begin
        if (!merged) begin
          for (int k = 0; k < NK; k++) begin
            if (hit[k]) begin
              a_iv[k] = (a_iv[k] == '1) ? a_iv[k] : a_iv[k] + CW'(1);
              a_tv[k] = (a_tv[k] == '1) ? a_tv[k] : a_tv[k] + CW'(1);
            end
          end
          if (s1_q.packet_size > a_lg) begin
            a_lg = s1_q.packet_size;
          end
        end
      end
      tfsc_pkg::ACT_CLEAR_INT: begin
        for (int k = 0; k < NK; k++) begin
          a_iv[k] = '0;
          b_iv[k] = '0;
        end
      end
      tfsc_pkg::ACT_CLEAR_ALL: begin
        for (int k = 0; k < NK; k++) begin
          a_iv[k] = '0;
          b_iv[k] = '0;
          a_tv[k] = '0;
          b_tv[k] = '0;
        end
        a_lg = '0;
        b_lg = '0;
      end
      tfsc_pkg::ACT_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      wdata[k*CW +: CW]          = a_iv[k];
      wdata[TotOff + k*CW +: CW] = a_tv[k];
    end
    wdata[LgOff +: SW] = a_lg;
  end

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      sum_iv[k] = {1'b0, a_iv[k]} + {1'b0, b_iv[k]};
      sum_tv[k] = {1'b0, a_tv[k]} + {1'b0, b_tv[k]};
      if (merged) begin
        rep_iv[k] = sum_iv[k][CW] ? '1 : sum_iv[k][CW-1:0];
        rep_tv[k] = sum_tv[k][CW] ? '1 : sum_tv[k][CW-1:0];
      end else begin
        rep_iv[k] = a_iv[k];
        rep_tv[k] = a_tv[k];
      end
    end
    rep_lg = (merged && (b_lg > a_lg)) ? b_lg : a_lg;
  end

  if (CW > OW) begin : g_clamp
    always_comb begin
      for (int k = 0; k < NK; k++) begin
        cl_iv[k] = (|rep_iv[k][CW-1:OW]) ? '1 : rep_iv[k][OW-1:0];
        cl_tv[k] = (|rep_tv[k][CW-1:OW]) ? '1 : rep_tv[k][OW-1:0];
      end
    end
  end else begin : g_extend
    always_comb begin
      for (int k = 0; k < NK; k++) begin
        cl_iv[k] = OW'(rep_iv[k]);
        cl_tv[k] = OW'(rep_tv[k]);
      end
    end
  end

  always_comb begin
    rsp.syn_interval         = cl_iv[tfsc_pkg::KIND_SYN];
    rsp.synack_interval      = cl_iv[tfsc_pkg::KIND_SYNACK];
    rsp.fin_interval         = cl_iv[tfsc_pkg::KIND_FIN];
    rsp.rst_interval         = cl_iv[tfsc_pkg::KIND_RST];
    rsp.zero_window_interval = cl_iv[tfsc_pkg::KIND_ZWIN];
    rsp.syn_total            = cl_tv[tfsc_pkg::KIND_SYN];
    rsp.synack_total         = cl_tv[tfsc_pkg::KIND_SYNACK];
    rsp.fin_total            = cl_tv[tfsc_pkg::KIND_FIN];
    rsp.rst_total            = cl_tv[tfsc_pkg::KIND_RST];
    rsp.zero_window_total    = cl_tv[tfsc_pkg::KIND_ZWIN];
    rsp.largest_packet       = rep_lg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      iv_q        <= '0;
      tv_q        <= '0;
      fwd_a_q     <= 1'b0;
      fwd_b_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
        // RAM returns old data when written at the read edge
        fwd_a_q    <= in_fire && we && (row_a == in_i.direction[0]);
        fwd_b_q    <= in_fire && we && (row_a == ~in_i.direction[0]);
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        case (s1_q.action)
          tfsc_pkg::ACT_PACKET: begin
            if (!merged) begin
              iv_q[row_a] <= 1'b1;
              tv_q[row_a] <= 1'b1;
            end
          end
          tfsc_pkg::ACT_CLEAR_INT: begin
            iv_q <= '0;
          end
          tfsc_pkg::ACT_CLEAR_ALL: begin
            iv_q <= '0;
            tv_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q       <= in_i;
      fwd_data_q <= wdata;
    end
    if (s1_fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_fwd_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_a_q && fwd_b_q))
    else $error("forwarding selected for both read ports");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_a_q || fwd_b_q) |-> s1_valid_q)
    else $error("forwarding flag without an item in the update stage");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_q.action == tfsc_pkg::ACT_CLEAR_ALL)) |=>
      (iv_q == '0) && (tv_q == '0))
    else $error("rows still valid after clear-all");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && s1_valid_q && !out_ready_i))
    else $error("request side stalled without a held result");

endmodule
